FILE: design/clrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package clrp_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int PC_W    = 5;   // processor count register
  localparam int POS_W   = 4;   // byte position within a field or vector
  localparam int CNT_W   = 8;   // dependency counter
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;
  localparam int PTR_W   = 64;
  localparam int SLOT_OUT_W = 4;

  // slots ever addressable through a 5-bit processor count
  localparam int PC_MAX = (1 << PC_W) - 1;

  localparam logic [BYTE_W-1:0] GROUP_MARK = 8'hff;
  localparam logic [CNT_W-1:0]  CNT_SAT    = 8'hff;
  localparam logic [POS_W-1:0]  COUNT_LAST = 4'd3;
  localparam logic [POS_W-1:0]  PTR_LAST   = 4'd7;

  typedef struct packed {
    logic pos_clear;
    logic proc_load;
    logic proc_zero;
    logic thread_load;
    logic count_byte;
    logic ptr_byte;
    logic vec_byte;
    logic cnt_clear;
    logic emit_load;
    logic slot_inc;
    logic slot_clear;
  } cmd_t;

  typedef struct packed {
    logic serial;
    logic count_last;
    logic ptr_last;
    logic vec_last;
    logic slot_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: design/clrp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module clrp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           log_byte,
  input  wire logic                 cfg_we,
  input  wire clrp_pkg::status_t    st,
  output clrp_pkg::cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_WAIT,
    S_THREAD,
    S_COUNT,
    S_POINTER,
    S_REC_VEC,
    S_GRP_VEC,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   acc;

  assign acc = in_valid & ~in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (cfg_we) begin
      // register write aborts the record and wipes the counters
      state_next     = S_WAIT;
      cmd.pos_clear  = 1'b1;
      cmd.cnt_clear  = 1'b1;
      cmd.slot_clear = 1'b1;
    end else begin
      unique case (state)
        S_WAIT: begin
          if (acc) begin
            cmd.pos_clear = 1'b1;
            if (st.serial) begin
              cmd.proc_zero   = 1'b1;
              cmd.thread_load = 1'b1;
              state_next      = S_COUNT;
            end else if (log_byte == clrp_pkg::GROUP_MARK) begin
              state_next = S_GRP_VEC;
            end else begin
              cmd.proc_load = 1'b1;
              state_next    = S_THREAD;
            end
          end
        end
        S_THREAD: begin
          if (acc) begin
            cmd.thread_load = 1'b1;
            cmd.pos_clear   = 1'b1;
            state_next      = S_COUNT;
          end
        end
        S_COUNT: begin
          if (acc) begin
            cmd.count_byte = 1'b1;
            if (st.count_last) begin
              cmd.pos_clear = 1'b1;
              state_next    = S_POINTER;
            end
          end
        end
        S_POINTER: begin
          if (acc) begin
            cmd.ptr_byte = 1'b1;
            if (st.ptr_last) begin
              cmd.pos_clear = 1'b1;
              state_next    = st.serial ? S_EMIT : S_REC_VEC;
            end
          end
        end
        S_REC_VEC: begin
          if (acc) begin
            cmd.vec_byte = 1'b1;
            if (st.vec_last) begin
              cmd.pos_clear = 1'b1;
              state_next    = S_EMIT;
            end
          end
        end
        S_GRP_VEC: begin
          if (acc) begin
            cmd.vec_byte = 1'b1;
            if (st.vec_last) begin
              cmd.pos_clear = 1'b1;
              state_next    = S_WAIT;
            end
          end
        end
        S_EMIT: begin
          if (st.out_free) begin
            cmd.emit_load = 1'b1;
            if (st.slot_last) begin
              cmd.cnt_clear  = 1'b1;
              cmd.slot_clear = 1'b1;
              state_next     = S_WAIT;
            end else begin
              cmd.slot_inc = 1'b1;
            end
          end
        end
        default: begin
          state_next = S_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WAIT;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      // input is held off for the whole result burst
      in_stall <= (state_next == S_EMIT);
    end
  end

endmodule
`default_nettype wire

FILE: design/clrp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module clrp_dp #(
  parameter int MAX_PROCS = clrp_pkg::MAX_PROCS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [7:0]                        log_byte,
  input  wire logic                              cfg_we,
  input  wire logic [clrp_pkg::PC_W-1:0]         cfg_data,
  input  wire clrp_pkg::cmd_t                    cmd,
  output clrp_pkg::status_t                      st,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             record_proc,
  output logic [7:0]                             record_thread,
  output logic [clrp_pkg::COUNT_W-1:0]           instruction_count,
  output logic [clrp_pkg::PTR_W-1:0]             instruction_pointer,
  output logic [clrp_pkg::SLOT_OUT_W-1:0]        slot_index,
  output logic [clrp_pkg::CNT_W-1:0]             successor_count,
  output logic [clrp_pkg::CNT_W-1:0]             predecessor_count,
  output logic                                   last_of_record
);

  // only slots reachable by a 5-bit count are stored
  localparam int SLOTS  = (MAX_PROCS < clrp_pkg::PC_MAX) ? MAX_PROCS : clrp_pkg::PC_MAX;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PC_W   = clrp_pkg::PC_W;
  localparam int POS_W  = clrp_pkg::POS_W;
  localparam int CNT_W  = clrp_pkg::CNT_W;

  logic [PC_W-1:0]                  proc_cnt;
  logic [PC_W-1:0]                  n_procs;
  logic [POS_W-1:0]                 vec_size;
  logic [PC_W+1:0]                  vec_bits;
  logic [POS_W-1:0]                 pos;
  logic [PC_W-1:0]                  slot;
  logic [7:0]                       held_proc;
  logic [7:0]                       held_thread;
  logic [clrp_pkg::COUNT_W-1:0]     held_count;
  logic [clrp_pkg::PTR_W-1:0]       held_ptr;
  logic [CNT_W-1:0]                 succ_cnt [SLOTS];
  logic [CNT_W-1:0]                 pred_cnt [SLOTS];
  logic [SLOTS-1:0]                 succ_hit;
  logic [SLOTS-1:0]                 pred_hit;

  // bit at vector position idx is in the current byte and set
  function automatic logic vec_hit(input logic [7:0] b, input logic [POS_W-1:0] p,
                                   input logic [PC_W:0] idx);
    logic in_byte;
    in_byte = (POS_W'(idx[PC_W:3]) == p);
    return in_byte & b[idx[2:0]];
  endfunction

  always_comb begin
    if (proc_cnt <= PC_W'(1)) begin
      n_procs = PC_W'(1);
    end else if (proc_cnt > PC_W'(SLOTS)) begin
      n_procs = PC_W'(SLOTS);
    end else begin
      n_procs = proc_cnt;
    end
  end

  assign vec_bits = {n_procs, 1'b0} + (PC_W+2)'(7);
  assign vec_size = POS_W'(vec_bits[PC_W+1:3]);

  assign st.serial     = (proc_cnt <= PC_W'(1));
  assign st.count_last = (pos == clrp_pkg::COUNT_LAST);
  assign st.ptr_last   = (pos == clrp_pkg::PTR_LAST);
  assign st.vec_last   = ((pos + POS_W'(1)) >= vec_size);
  assign st.slot_last  = ((slot + PC_W'(1)) == n_procs);
  assign st.out_free   = ~out_valid | ~out_stall;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      succ_hit[k] = (PC_W'(k) < n_procs) & vec_hit(log_byte, pos, (PC_W+1)'(k));
      pred_hit[k] = (PC_W'(k) < n_procs)
                  & vec_hit(log_byte, pos, (PC_W+1)'(n_procs) + (PC_W+1)'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_cnt  <= PC_W'(1);
      pos       <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
      held_proc   <= '0;
      held_thread <= '0;
      held_count  <= '0;
      held_ptr    <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        succ_cnt[k] <= '0;
        pred_cnt[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        proc_cnt <= cfg_data;
      end

      if (cmd.pos_clear) begin
        pos <= '0;
      end else if (cmd.count_byte | cmd.ptr_byte | cmd.vec_byte) begin
        pos <= pos + POS_W'(1);
      end

      if (cmd.slot_clear) begin
        slot <= '0;
      end else if (cmd.slot_inc) begin
        slot <= slot + PC_W'(1);
      end

      if (cmd.proc_zero) begin
        held_proc <= '0;
      end else if (cmd.proc_load) begin
        held_proc <= log_byte;
      end
      if (cmd.thread_load) begin
        held_thread <= log_byte;
      end
      if (cmd.count_byte) begin
        held_count[8*pos[1:0] +: 8] <= log_byte;
      end
      if (cmd.ptr_byte) begin
        held_ptr[8*pos[2:0] +: 8] <= log_byte;
      end

      for (int k = 0; k < SLOTS; k++) begin
        if (cmd.cnt_clear) begin
          succ_cnt[k] <= '0;
          pred_cnt[k] <= '0;
        end else if (cmd.vec_byte) begin
          if (succ_hit[k] && succ_cnt[k] != clrp_pkg::CNT_SAT) begin
            succ_cnt[k] <= succ_cnt[k] + CNT_W'(1);
          end
          if (pred_hit[k] && pred_cnt[k] != clrp_pkg::CNT_SAT) begin
            pred_cnt[k] <= pred_cnt[k] + CNT_W'(1);
          end
        end
      end

      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      record_proc         <= held_proc;
      record_thread       <= held_thread;
      instruction_count   <= held_count;
      instruction_pointer <= held_ptr;
      slot_index          <= slot[clrp_pkg::SLOT_OUT_W-1:0];
      successor_count     <= succ_cnt[slot[SLOT_W-1:0]];
      predecessor_count   <= pred_cnt[slot[SLOT_W-1:0]];
      last_of_record      <= st.slot_last;
    end
  end

endmodule
`default_nettype wire

FILE: design/chunk_log_record_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Chunk log record parser. Log bytes are taken one per cycle while a record or
// dependency group is being parsed. When a record completes, one result beat per
// processor slot (one beat in serial mode) leaves through a single output
// register at up to one beat per cycle; the input is stalled for that burst. A
// parallel record is 14 + V bytes (V = vector bytes) and a serial record 13 bytes.
// The burst length is set by the slot sequencer, which reads one counter pair per
// cycle while the output register is free. The register write port is always
// ready; a write aborts any partial record and clears the counters.
module chunk_log_record_parser_core #(
  parameter int MAX_PROCS = clrp_pkg::MAX_PROCS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    log_byte,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [clrp_pkg::PC_W-1:0]     processor_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         record_proc,
  output logic [7:0]                         record_thread,
  output logic [clrp_pkg::COUNT_W-1:0]       instruction_count,
  output logic [clrp_pkg::PTR_W-1:0]         instruction_pointer,
  output logic [clrp_pkg::SLOT_OUT_W-1:0]    slot_index,
  output logic [clrp_pkg::CNT_W-1:0]         successor_count,
  output logic [clrp_pkg::CNT_W-1:0]         predecessor_count,
  output logic                               last_of_record
);

  clrp_pkg::cmd_t    cmd;
  clrp_pkg::status_t st;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  clrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .log_byte (log_byte),
    .cfg_we   (cfg_we),
    .st       (st),
    .cmd      (cmd)
  );

  clrp_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .log_byte            (log_byte),
    .cfg_we              (cfg_we),
    .cfg_data            (processor_count),
    .cmd                 (cmd),
    .st                  (st),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .record_proc         (record_proc),
    .record_thread       (record_thread),
    .instruction_count   (instruction_count),
    .instruction_pointer (instruction_pointer),
    .slot_index          (slot_index),
    .successor_count     (successor_count),
    .predecessor_count   (predecessor_count),
    .last_of_record      (last_of_record)
  );

  // a result beat is never loaded over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> st.out_free)
    else $error("result beat overwritten");

  // mid-burst the input stays held off
  a_burst_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load && !st.slot_last && !cfg_we |=> in_stall)
    else $error("input taken during result burst");

  // one datapath action per cycle
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.thread_load, cmd.count_byte, cmd.ptr_byte, cmd.vec_byte, cmd.emit_load}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

FILE: tb/sv/chunk_log_record_parser_core_test.sv
`timescale 1ns / 1ps
module chunk_log_record_parser_core_test;
  import clrp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int CFG_SETTLE  = 24;
  localparam int NSLOTS      = MAX_PROCS_DEF;

  typedef enum logic [2:0] {
    AWAIT_START,
    GET_THREAD,
    GET_COUNT,
    GET_POINTER,
    GET_REC_VEC,
    GET_GRP_VEC
  } parse_step_t;

  typedef struct {
    logic [7:0]         proc;
    logic [7:0]         thread;
    logic [COUNT_W-1:0] icount;
    logic [PTR_W-1:0]   iptr;
    logic [3:0]         slot;
    logic [CNT_W-1:0]   succ;
    logic [CNT_W-1:0]   pred;
    logic               last;
  } slot_report_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            log_byte;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PC_W-1:0]       processor_count;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            record_proc;
  logic [7:0]            record_thread;
  logic [COUNT_W-1:0]    instruction_count;
  logic [PTR_W-1:0]      instruction_pointer;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [CNT_W-1:0]      successor_count;
  logic [CNT_W-1:0]      predecessor_count;
  logic                  last_of_record;

  chunk_log_record_parser_core uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .log_byte            (log_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .processor_count     (processor_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .record_proc         (record_proc),
    .record_thread       (record_thread),
    .instruction_count   (instruction_count),
    .instruction_pointer (instruction_pointer),
    .slot_index          (slot_index),
    .successor_count     (successor_count),
    .predecessor_count   (predecessor_count),
    .last_of_record      (last_of_record)
  );

  // parser mirror
  logic [PC_W-1:0]    model_pc;
  parse_step_t        step;
  int                 pos;
  logic [7:0]         rec_proc;
  logic [7:0]         rec_thread;
  logic [COUNT_W-1:0] rec_count;
  logic [PTR_W-1:0]   rec_ptr;
  logic [CNT_W-1:0]   succ_cnt [NSLOTS];
  logic [CNT_W-1:0]   pred_cnt [NSLOTS];
  slot_report_t       pending_reports [$];

  int errors;
  int bytes_sent;
  int reports_seen;
  int records_seen;
  int cfg_writes;
  int in_gap_max;
  int out_gap_max;
  int out_wait_left;
  int hold_left;
  int quiet_cycles;

  function automatic int slots_now();
    if (model_pc <= 1) return 1;
    if (model_pc > NSLOTS) return NSLOTS;
    return int'(model_pc);
  endfunction

  function automatic int vec_bytes();
    return (2 * slots_now() + 7) / 8;
  endfunction

  function automatic void clear_dep_counts();
    foreach (succ_cnt[i]) begin
      succ_cnt[i] = '0;
      pred_cnt[i] = '0;
    end
  endfunction

  // one bit-vector byte; returns 1 when the vector is complete
  function automatic bit take_vector_byte(logic [7:0] b, int n);
    int p;
    for (int i = 0; i < 8; i++) begin
      p = pos * 8 + i;
      if (b[i]) begin
        if (p < n) begin
          if (succ_cnt[p] != CNT_SAT) succ_cnt[p] = succ_cnt[p] + 1'b1;
        end else if (p < 2 * n) begin
          if (pred_cnt[p - n] != CNT_SAT) pred_cnt[p - n] = pred_cnt[p - n] + 1'b1;
        end
      end
    end
    pos++;
    if (pos >= (2 * n + 7) / 8) begin
      pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_burst(int n, bit serial_mode);
    slot_report_t r;
    for (int s = 0; s < n; s++) begin
      r.proc   = serial_mode ? 8'h00 : rec_proc;
      r.thread = rec_thread;
      r.icount = rec_count;
      r.iptr   = rec_ptr;
      r.slot   = s[3:0];
      r.succ   = succ_cnt[s];
      r.pred   = pred_cnt[s];
      r.last   = (s == n - 1);
      pending_reports.push_back(r);
    end
    clear_dep_counts();
    step = AWAIT_START;
    pos  = 0;
  endfunction

  function automatic void parse_log_byte(logic [7:0] b);
    int n;
    bit serial_mode;
    n = slots_now();
    serial_mode = (model_pc <= 1);
    case (step)
      AWAIT_START: begin
        pos = 0;
        if (serial_mode) begin
          rec_proc   = 8'h00;
          rec_thread = b;
          step       = GET_COUNT;
        end else if (b == GROUP_MARK) begin
          step = GET_GRP_VEC;
        end else begin
          rec_proc = b;
          step     = GET_THREAD;
        end
      end
      GET_THREAD: begin
        rec_thread = b;
        pos        = 0;
        step       = GET_COUNT;
      end
      GET_COUNT: begin
        rec_count[pos*8 +: 8] = b;
        pos++;
        if (pos >= 4) begin
          pos  = 0;
          step = GET_POINTER;
        end
      end
      GET_POINTER: begin
        rec_ptr[pos*8 +: 8] = b;
        pos++;
        if (pos >= 8) begin
          pos = 0;
          if (serial_mode) queue_burst(1, 1'b1);
          else step = GET_REC_VEC;
        end
      end
      GET_REC_VEC: begin
        if (take_vector_byte(b, n)) queue_burst(n, 1'b0);
      end
      GET_GRP_VEC: begin
        if (take_vector_byte(b, n)) step = AWAIT_START;
      end
      default: begin
        step = AWAIT_START;
        pos  = 0;
      end
    endcase
  endfunction

  function automatic void apply_proc_count(logic [PC_W-1:0] v);
    model_pc = v;
    step     = AWAIT_START;
    pos      = 0;
    clear_dep_counts();
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void check_field(string tag, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random stall per beat, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_wait_left > 0) begin
      out_wait_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beat
    slot_report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got slot %0d proc %0h",
                 $time, slot_index, record_proc);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("record_proc", want.proc, record_proc);
        check_field("record_thread", want.thread, record_thread);
        check_field("instruction_count", want.icount, instruction_count);
        check_field("instruction_pointer", want.iptr, instruction_pointer);
        check_field("slot_index", want.slot, slot_index);
        check_field("successor_count", want.succ, successor_count);
        check_field("predecessor_count", want.pred, predecessor_count);
        check_field("last_of_record", want.last, last_of_record);
        if (want.last) records_seen++;
      end
      out_wait_left = $urandom_range(0, out_gap_max);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // all tasks below start and end on a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    log_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_log_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_group(input logic [31:0] bits);
    send_byte(GROUP_MARK);
    for (int i = 0; i < vec_bytes(); i++) send_byte(bits[i*8 +: 8]);
  endtask

  task automatic send_record(input logic [7:0] proc_b, input logic [7:0] thread_b,
                             input logic [31:0] cnt, input logic [63:0] ptr,
                             input logic [31:0] bits);
    if (model_pc > 1) send_byte(proc_b);
    send_byte(thread_b);
    for (int i = 0; i < 4; i++) send_byte(cnt[i*8 +: 8]);
    for (int i = 0; i < 8; i++) send_byte(ptr[i*8 +: 8]);
    if (model_pc > 1)
      for (int i = 0; i < vec_bytes(); i++) send_byte(bits[i*8 +: 8]);
  endtask

  task automatic wait_for_results(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_proc_count(input logic [PC_W-1:0] v);
    wait_for_results(CFG_SETTLE);
    cfg_valid       <= 1'b1;
    processor_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_proc_count(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_record();
    send_record(8'($urandom_range(0, 254)), pick_byte(),
                {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                {pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                 pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : 32'($urandom));
  endtask

  task automatic test_serial_extremes();
    in_gap_max  = 8;
    out_gap_max = 8;
    send_record(8'h00, 8'hff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 32'h0);
    wait_for_results(0);
  endtask

  // two slots: a full group with unused high bits set, then a record with zero fields
  task automatic test_parallel_basics();
    write_proc_count(5'd2);
    send_group(32'h0000_00ff);
    send_record(8'h00, 8'h00, 32'h0, 64'h0, 32'h0000_00f6);
    wait_for_results(0);
  endtask

  task automatic test_abort_and_clamp();
    write_proc_count(5'd31);
    send_group(32'hffff_ffff);
    send_byte(8'h05);
    send_byte(8'h07);
    repeat (3) send_byte(pick_byte());
    // partial record and counters dropped; zero count means serial
    write_proc_count(5'd0);
    random_record();
    write_proc_count(5'd16);
    send_byte(GROUP_MARK);
    send_byte(8'hff);
    send_byte(8'hff);
    write_proc_count(5'd16);
    send_record(8'hfe, pick_byte(), 32'($urandom), {32'($urandom), 32'($urandom)},
                32'($urandom));
    wait_for_results(0);
  endtask

  // several groups pile up on the counters before a record reports them
  task automatic test_accumulation();
    in_gap_max  = 0;
    out_gap_max = 0;
    write_proc_count(5'd2);
    repeat (6) send_group(32'h0000_00ff);
    send_record(8'h01, 8'h02, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 32'h0000_00ff);
    wait_for_results(0);
  endtask

  task automatic test_backpressure();
    in_gap_max  = 0;
    out_gap_max = 2;
    write_proc_count(5'd16);
    @(posedge clk);
    hold_left = 150;
    @(negedge clk);
    repeat (2) random_record();
    wait_for_results(0);
  endtask

  task automatic test_random_phases();
    logic [PC_W-1:0] phase_pc [6];
    int start;
    int sel;
    phase_pc = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd9, 5'd2};
    for (int ph = 0; ph < 6; ph++) begin
      in_gap_max  = (ph == 2) ? 0 : 8;
      out_gap_max = (ph == 4) ? 0 : 8;
      write_proc_count(phase_pc[ph]);
      start = bytes_sent;
      while (bytes_sent - start < 5) begin
        sel = $urandom_range(0, 99);
        if (model_pc <= 1 || sel < 60) begin
          random_record();
        end else if (sel < 90) begin
          send_group(($urandom_range(0, 3) == 0) ? 32'hffff_ffff : 32'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    wait_for_results(0);
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    log_byte        = 8'h00;
    cfg_valid       = 1'b0;
    processor_count = 5'd1;
    out_stall       = 1'b0;
    errors          = 0;
    bytes_sent      = 0;
    reports_seen    = 0;
    records_seen    = 0;
    cfg_writes      = 0;
    in_gap_max      = 8;
    out_gap_max     = 8;
    out_wait_left   = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    rec_proc        = '0;
    rec_thread      = '0;
    rec_count       = '0;
    rec_ptr         = '0;
    apply_proc_count(5'd1);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_serial_extremes();
    test_parallel_basics();
    test_abort_and_clamp();
    test_accumulation();
    test_backpressure();
    test_random_phases();

    wait_for_results(30);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d slot reports never arrived", $time, pending_reports.size());
      errors++;
    end
    $display("Fed %0d log bytes over %0d register writes; checked %0d slot beats in %0d records",
             bytes_sent, cfg_writes, reports_seen, records_seen);
    $display("Covered serial and clamped counts, aborts, counter buildup and long output hold-off");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
